// ===== src/nearest_value_distance_sum_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest value distance sum block.
// Each macro expands to one labeled concurrent assertion that is clocked by
// i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VALUE_DISTANCE_SUM_TOP_MACROS_SVH
`define NEAREST_VALUE_DISTANCE_SUM_TOP_MACROS_SVH

// Same-cycle implication.
`define NVDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NVDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nvds_pkg.sv =====
// ----------------------------------------------------------------------------
// nvds_pkg
// Shared constants, types and bit-search helpers of the nearest value
// distance sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package nvds_pkg;

    localparam int SAMPLE_W = 21;
    localparam int COST_W   = 22;
    localparam int TOTAL_W  = 41;
    localparam int CAPACITY = 65536;
    localparam int COUNT_W  = 17;

    // Bit-tree geometry: 64-bit words, four levels over the 21-bit key.
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int L0_AW   = SAMPLE_W - BIT_W;
    localparam int L1_AW   = SAMPLE_W - 2 * BIT_W;
    localparam int L2_AW   = SAMPLE_W - 3 * BIT_W;
    localparam int L2_N    = 1 << L2_AW;
    localparam int EPOCH_W = 8;
    localparam int MEM_W   = WORD_W + EPOCH_W;

    localparam logic [COUNT_W-1:0] CAP_COUNT  = COUNT_W'(CAPACITY);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {1'b0, {(TOTAL_W - 1){1'b1}}};
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    typedef enum logic [1:0] {
        RT_DONE,
        RT_L0,
        RT_L1,
        RT_L2
    } t_route;

    typedef struct packed {
        logic idle;
        logic clr;
        logic rd_base;
        logic cap;
        logic plan;
        logic l2;
        logic l1;
        logic l0;
        logic cost;
        logic fin;
        logic dir;
    } t_cmd;

    typedef struct packed {
        logic   fire;
        logic   wrap;
        logic   clr_last;
        t_route route;
        logic   out_free;
    } t_sts;

    function automatic logic [BIT_W-1:0] hi_idx(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] lo_idx(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Highest set bit when searching downward, lowest when searching upward.
    function automatic logic [BIT_W-1:0] pick(input logic [WORD_W-1:0] w,
                                              input logic up);
        return up ? lo_idx(w) : hi_idx(w);
    endfunction

    // Bits on the search side of position b, with or without b itself.
    function automatic logic [WORD_W-1:0] side_mask(input logic [BIT_W-1:0] b,
                                                    input logic up,
                                                    input logic incl);
        logic [WORD_W-1:0] ones;
        logic [WORD_W-1:0] m;
        ones = '1;
        if (up) begin
            m = incl ? (ones << b) : ((ones << b) << 1);
        end else begin
            m = incl ? (ones >> (BIT_W'(WORD_W - 1) - b)) : ~(ones << b);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/nvds_ifs.sv =====
// ----------------------------------------------------------------------------
// nvds channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nvds_in_if;
    logic                                valid;
    logic                                ready;
    logic                                start_req;
    logic signed [nvds_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output start_req, output sample, input ready);
    modport sink (input valid, input start_req, input sample, output ready);
endinterface

interface nvds_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [nvds_pkg::COST_W-1:0]  item_cost;
    logic signed [nvds_pkg::TOTAL_W-1:0] running_total;
    logic                               store_full;

    modport source (output valid, output item_cost, output running_total,
                    output store_full, input ready);
    modport sink (input valid, input item_cost, input running_total,
                  input store_full, output ready);
endinterface

`default_nettype wire

// ===== src/nvds_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvds_ctrl
// Sequencer for clearing, bit-tree searches and insertion of one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_value_distance_sum_top_macros.svh"

module nvds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nvds_pkg::t_sts i_sts,
    output nvds_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_CAP,
        S_PLAN,
        S_L2,
        S_L1,
        S_L0,
        S_COST,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_dir;
    logic   r_after;

    always_comb begin
        o_cmd     = '0;
        o_cmd.dir = r_dir;
        case (r_state)
            S_CLR:   o_cmd.clr     = 1'b1;
            S_IDLE:  o_cmd.idle    = 1'b1;
            S_RD:    o_cmd.rd_base = 1'b1;
            S_CAP:   o_cmd.cap     = 1'b1;
            S_PLAN:  o_cmd.plan    = 1'b1;
            S_L2:    o_cmd.l2      = 1'b1;
            S_L1:    o_cmd.l1      = 1'b1;
            S_L0:    o_cmd.l0      = 1'b1;
            S_COST:  o_cmd.cost    = 1'b1;
            S_FIN:   o_cmd.fin     = 1'b1;
            default: o_cmd         = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_dir   <= 1'b0;
            r_after <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_sts.clr_last) begin
                        r_state <= r_after ? S_RD : S_IDLE;
                        r_after <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_dir <= 1'b0;
                    if (i_sts.fire) begin
                        if (i_sts.wrap) begin
                            r_state <= S_CLR;
                            r_after <= 1'b1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD:  r_state <= S_CAP;
                S_CAP: r_state <= S_PLAN;
                S_PLAN: begin
                    case (i_sts.route)
                        nvds_pkg::RT_L0: r_state <= S_L0;
                        nvds_pkg::RT_L1: r_state <= S_L1;
                        nvds_pkg::RT_L2: r_state <= S_L2;
                        default: begin
                            if (!r_dir) begin
                                r_dir <= 1'b1;
                            end else begin
                                r_state <= S_COST;
                            end
                        end
                    endcase
                end
                S_L2: r_state <= S_L1;
                S_L1: r_state <= S_L0;
                S_L0: begin
                    if (!r_dir) begin
                        r_dir   <= 1'b1;
                        r_state <= S_PLAN;
                    end else begin
                        r_state <= S_COST;
                    end
                end
                S_COST: r_state <= S_FIN;
                S_FIN: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `NVDS_ASSERT_IMP(a_l0_entry, r_state == S_L0, $past(r_state) == S_L1 || $past(r_state) == S_PLAN, "L0 step without a preceding plan or L1 step")
    `NVDS_ASSERT_IMP(a_l1_entry, r_state == S_L1, $past(r_state) == S_L2 || $past(r_state) == S_PLAN, "L1 step without a preceding plan or L2 step")
    `NVDS_ASSERT_IMP(a_cost_dir, r_state == S_COST, r_dir, "cost step before the upward search")

endmodule

`default_nettype wire

// ===== src/nvds_dp.sv =====
// ----------------------------------------------------------------------------
// nvds_dp
// Four-level bit tree with epoch-tagged memories, nearest-value search,
// cost, saturating total and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_value_distance_sum_top_macros.svh"

module nvds_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nvds_pkg::t_cmd  i_cmd,
    output nvds_pkg::t_sts  o_sts,
    nvds_in_if.sink         i_in,
    nvds_out_if.source      o_out
);

    localparam int WW = nvds_pkg::WORD_W;
    localparam int BW = nvds_pkg::BIT_W;
    localparam int SW = nvds_pkg::SAMPLE_W;

    // Leaf words and first summary level live in memories.
    logic [nvds_pkg::MEM_W-1:0] mem0 [0:(1 << nvds_pkg::L0_AW)-1];
    logic [nvds_pkg::MEM_W-1:0] mem1 [0:(1 << nvds_pkg::L1_AW)-1];

    logic [SW-1:0]                    r_u;
    logic [nvds_pkg::EPOCH_W-1:0]     r_epoch;
    logic [nvds_pkg::L0_AW-1:0]       r_clr;
    logic [WW-1:0]                    r_w0;
    logic [WW-1:0]                    r_w1;
    logic [WW-1:0]                    r_l2 [nvds_pkg::L2_N];
    logic [nvds_pkg::L2_N-1:0]        r_l3;
    logic [nvds_pkg::COUNT_W-1:0]     r_count;
    logic [nvds_pkg::TOTAL_W-1:0]     r_total;
    logic [nvds_pkg::L0_AW-1:0]       r_a0;
    logic [nvds_pkg::L1_AW-1:0]       r_a1;
    logic [nvds_pkg::L2_AW-1:0]       r_m;
    logic [nvds_pkg::MEM_W-1:0]       r_q0;
    logic [nvds_pkg::MEM_W-1:0]       r_q1;
    logic                             r_pred_f;
    logic [SW-1:0]                    r_pred_v;
    logic                             r_succ_f;
    logic [SW-1:0]                    r_succ_v;
    logic signed [nvds_pkg::COST_W-1:0] r_cost;
    logic                             r_o_valid;
    logic signed [nvds_pkg::COST_W-1:0] r_o_cost;
    logic [nvds_pkg::TOTAL_W-1:0]     r_o_total;
    logic                             r_o_full;

    logic [BW-1:0]                w_b0, w_b1, w_b2;
    logic [nvds_pkg::L2_AW-1:0]   w_b3;
    logic [WW-1:0]                w_d0, w_d1;
    logic [WW-1:0]                w_w0m, w_w1m, w_w2m, w_w3mask, w_w3ext;
    logic [BW-1:0]                w_pk0, w_pk1, w_pk2, w_pk3, w_pkl2, w_pkq1, w_pkq0;
    logic [nvds_pkg::L0_AW-1:0]   s_a0;
    logic [nvds_pkg::L1_AW-1:0]   s_a1;
    logic [nvds_pkg::L2_AW-1:0]   n_m;
    nvds_pkg::t_route             w_route;
    logic                         w_res_f;
    logic [SW-1:0]                w_res_v;
    logic                         w_rec;
    logic                         w_fire;
    logic                         w_out_free;
    logic                         w_dup;
    logic                         w_at_cap;
    logic                         w_ins;
    logic                         w_load;
    logic [WW-1:0]                w_one;
    logic [nvds_pkg::COST_W-1:0]  w_dp, w_ds;
    logic signed [nvds_pkg::COST_W-1:0] n_cost;
    logic signed [nvds_pkg::TOTAL_W:0]  w_sum;
    logic [nvds_pkg::TOTAL_W-1:0] n_total;

    function automatic logic [WW-1:0] live(input logic [nvds_pkg::MEM_W-1:0] q,
                                           input logic [nvds_pkg::EPOCH_W-1:0] ep);
        return (q[nvds_pkg::MEM_W-1:WW] == ep) ? q[WW-1:0] : '0;
    endfunction

    assign w_b0 = r_u[BW-1:0];
    assign w_b1 = r_u[2*BW-1:BW];
    assign w_b2 = r_u[3*BW-1:2*BW];
    assign w_b3 = r_u[SW-1:3*BW];
    assign w_one = {{(WW - 1){1'b0}}, 1'b1};

    assign w_d0 = live(r_q0, r_epoch);
    assign w_d1 = live(r_q1, r_epoch);

    // Candidate words on the search side of the key at each level.
    assign w_w0m    = r_w0 & nvds_pkg::side_mask(w_b0, i_cmd.dir, 1'b1);
    assign w_w1m    = r_w1 & nvds_pkg::side_mask(w_b1, i_cmd.dir, 1'b0);
    assign w_w2m    = r_l2[w_b3] & nvds_pkg::side_mask(w_b2, i_cmd.dir, 1'b0);
    assign w_w3mask = nvds_pkg::side_mask(BW'(w_b3), i_cmd.dir, 1'b0);
    assign w_w3ext  = {{(WW - nvds_pkg::L2_N){1'b0}}, r_l3 & w_w3mask[nvds_pkg::L2_N-1:0]};

    assign w_pk0  = nvds_pkg::pick(w_w0m, i_cmd.dir);
    assign w_pk1  = nvds_pkg::pick(w_w1m, i_cmd.dir);
    assign w_pk2  = nvds_pkg::pick(w_w2m, i_cmd.dir);
    assign w_pk3  = nvds_pkg::pick(w_w3ext, i_cmd.dir);
    assign w_pkl2 = nvds_pkg::pick(r_l2[r_m], i_cmd.dir);
    assign w_pkq1 = nvds_pkg::pick(w_d1, i_cmd.dir);
    assign w_pkq0 = nvds_pkg::pick(w_d0, i_cmd.dir);

    always_comb begin
        s_a0    = r_a0;
        s_a1    = r_a1;
        n_m     = r_m;
        w_route = nvds_pkg::RT_DONE;
        w_res_f = 1'b0;
        w_res_v = r_u;
        if (i_cmd.rd_base) begin
            s_a0 = r_u[SW-1:BW];
            s_a1 = r_u[SW-1:2*BW];
        end else if (i_cmd.plan) begin
            if (w_w0m != '0) begin
                w_res_f = 1'b1;
                w_res_v = {r_u[SW-1:BW], w_pk0};
            end else if (w_w1m != '0) begin
                s_a0    = {r_u[SW-1:2*BW], w_pk1};
                w_route = nvds_pkg::RT_L0;
            end else if (w_w2m != '0) begin
                s_a1    = {w_b3, w_pk2};
                w_route = nvds_pkg::RT_L1;
            end else if (w_w3ext != '0) begin
                n_m     = w_pk3[nvds_pkg::L2_AW-1:0];
                w_route = nvds_pkg::RT_L2;
            end
        end else if (i_cmd.l2) begin
            s_a1    = {r_m, w_pkl2};
            w_route = nvds_pkg::RT_L1;
        end else if (i_cmd.l1) begin
            s_a0    = {r_a1, w_pkq1};
            w_route = nvds_pkg::RT_L0;
        end else if (i_cmd.l0) begin
            w_res_f = 1'b1;
            w_res_v = {r_a0, w_pkq0};
        end
    end

    assign w_rec = (i_cmd.plan && (w_route == nvds_pkg::RT_DONE)) || i_cmd.l0;

    assign w_fire     = i_cmd.idle && i_in.valid;
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_dup      = r_w0[w_b0];
    assign w_at_cap   = (r_count == nvds_pkg::CAP_COUNT);
    assign w_load     = i_cmd.fin && w_out_free;
    assign w_ins      = w_load && !w_dup && !w_at_cap;

    // Distances in the offset-binary domain equal the signed distances.
    assign w_dp = {1'b0, r_u} - {1'b0, r_pred_v};
    assign w_ds = {1'b0, r_succ_v} - {1'b0, r_u};

    always_comb begin
        if (r_count == '0) begin
            n_cost = {~r_u[SW-1], ~r_u[SW-1], r_u[SW-2:0]};
        end else if (r_pred_f && r_succ_f) begin
            n_cost = (w_dp < w_ds) ? w_dp : w_ds;
        end else if (r_pred_f) begin
            n_cost = w_dp;
        end else begin
            n_cost = w_ds;
        end
    end

    assign w_sum = {r_total[nvds_pkg::TOTAL_W-1], r_total}
                 + {{(nvds_pkg::TOTAL_W + 1 - nvds_pkg::COST_W){r_cost[nvds_pkg::COST_W-1]}},
                    r_cost};
    assign n_total = (!w_sum[nvds_pkg::TOTAL_W] && w_sum[nvds_pkg::TOTAL_W-1])
                   ? nvds_pkg::TOTAL_MAX : w_sum[nvds_pkg::TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        r_q0 <= mem0[s_a0];
        r_q1 <= mem1[s_a1];
        if (i_cmd.clr) begin
            mem0[r_clr]                        <= '0;
            mem1[r_clr[nvds_pkg::L1_AW-1:0]]  <= '0;
        end else if (w_ins) begin
            mem0[r_u[SW-1:BW]]   <= {r_epoch, r_w0 | (w_one << w_b0)};
            mem1[r_u[SW-1:2*BW]] <= {r_epoch, r_w1 | (w_one << w_b1)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0 <= s_a0;
        r_a1 <= s_a1;
        r_m  <= n_m;
        if (w_fire) begin
            r_u <= {~i_in.sample[SW-1], i_in.sample[SW-2:0]};
        end
        if (i_cmd.cap) begin
            r_w0 <= w_d0;
            r_w1 <= w_d1;
        end
        if (w_rec && !i_cmd.dir) begin
            r_pred_f <= w_res_f;
            r_pred_v <= w_res_v;
        end
        if (w_rec && i_cmd.dir) begin
            r_succ_f <= w_res_f;
            r_succ_v <= w_res_v;
        end
        if (i_cmd.cost) begin
            r_cost <= n_cost;
        end
        if (w_load) begin
            r_o_cost  <= r_cost;
            r_o_total <= n_total;
            r_o_full  <= !w_dup && w_at_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch   <= '0;
            r_clr     <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_l3      <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < nvds_pkg::L2_N; i++) begin
                r_l2[i] <= '0;
            end
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == '1) begin
                    r_epoch <= '0;
                end
            end
            if (w_fire && i_in.start_req) begin
                r_count <= '0;
                r_total <= '0;
                r_l3    <= '0;
                for (int i = 0; i < nvds_pkg::L2_N; i++) begin
                    r_l2[i] <= '0;
                end
                if (r_epoch != nvds_pkg::EPOCH_LAST) begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if (w_load) begin
                r_total <= n_total;
            end
            if (w_ins) begin
                r_count          <= r_count + 1'b1;
                r_l2[w_b3][w_b2] <= 1'b1;
                r_l3[w_b3]       <= 1'b1;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready          = i_cmd.idle;
    assign o_out.valid         = r_o_valid;
    assign o_out.item_cost     = r_o_cost;
    assign o_out.running_total = r_o_total;
    assign o_out.store_full    = r_o_full;

    assign o_sts.fire     = w_fire;
    assign o_sts.wrap     = w_fire && i_in.start_req && (r_epoch == nvds_pkg::EPOCH_LAST);
    assign o_sts.clr_last = (r_clr == '1);
    assign o_sts.route    = w_route;
    assign o_sts.out_free = w_out_free;

    `NVDS_ASSERT_IMP(a_nonempty_summary, r_count != '0, r_l3 != '0, "stored values but empty top summary")
    `NVDS_ASSERT_NXT(a_insert_count, w_ins, r_count == $past(r_count) + 1'b1, "insert did not bump the count")
    `NVDS_ASSERT_NXT(a_result_shown, w_load, o_out.valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== src/nearest_value_distance_sum_top.sv =====
// One item at a time: the input is ready only while the block is idle.
// Each search direction needs one to four steps, one per tree level that must be read.
// Reset (synchronous, active low) starts a clearing pass over all 32768 words of the leaf memory.
// A start item after 255 earlier starts repeats that clearing pass before it is processed.
// ----------------------------------------------------------------------------
// nearest_value_distance_sum_top
// Nearest stored value distance per item with a saturating running total.
// ----------------------------------------------------------------------------
`default_nettype none

// The set of stored values is a four-level bit tree over the 21-bit key in
// offset-binary form. The leaf words and the first summary level sit in two
// memories whose words carry an epoch tag, so that a start item empties the
// set by bumping the epoch; the two upper levels are flip-flops. Each item
// reads its own leaf and summary words, then searches downward for the
// predecessor and upward for the successor, descending through the tree one
// step per level. The cost, the saturating total and the insertion
// follow, and the result is held in an output register while the block
// takes the next item.
module nearest_value_distance_sum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nvds_in_if.sink    i_in,
    nvds_out_if.source o_out
);

    nvds_pkg::t_cmd w_cmd;
    nvds_pkg::t_sts w_sts;

    // The controller sequences clear, read, search and commit steps.
    nvds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the bit tree, the counters and the result register.
    nvds_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
